FILE: rtl/circle_point_generator_core_macros.svh
// Assertion macros used by the checker of the circle point generator.
`ifndef CIRCLE_POINT_GENERATOR_CORE_MACROS_SVH
`define CIRCLE_POINT_GENERATOR_CORE_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define CPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Consequent written as a sequence, checked from the antecedent cycle.
`define CPG_ASSERT_SEQ(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) else $error(msg);

`endif

FILE: rtl/cpg_pkg.sv
// Shared types and constants of the circle point generator.
package cpg_pkg;

    localparam int COORD_BITS   = 12;
    localparam int FRAC_BITS    = 20;
    localparam int WORK_BITS    = 30;
    localparam int STEP_BITS    = 13;
    localparam int PIX_BITS     = 14;
    localparam int COLOR_BITS   = 32;
    localparam int CFG_IDX_BITS = 3;
    localparam int NUM_TERMS    = 9;
    localparam int SUM_BITS     = 34;
    localparam int TERM_BITS    = 32;
    localparam int MUL_BITS     = 33;
    localparam int SHIFT_BITS   = 6;

    // Angle limits, pi/4 and pi/2 rounded to FRAC_BITS fraction bits
    localparam logic [FRAC_BITS:0] LIMIT_OCT  = 21'd823550;
    localparam logic [FRAC_BITS:0] LIMIT_QUAD = 21'd1647099;

    // Series denominators per term
    localparam int SIN_DIV [NUM_TERMS] = '{6, 20, 42, 72, 110, 156, 210, 272, 342};
    localparam int COS_DIV [NUM_TERMS] = '{2, 12, 30, 56, 90, 132, 182, 240, 306};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CENTER_X  = 3'd0,
        REG_CENTER_Y  = 3'd1,
        REG_RADIUS    = 3'd2,
        REG_COLOR     = 3'd3,
        REG_OCTANT    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic                       valid;
        logic                       skip;
        logic [TERM_BITS-1:0]       x2;
        logic [TERM_BITS-1:0]       ts;
        logic [TERM_BITS-1:0]       tc;
        logic signed [SUM_BITS-1:0] ssum;
        logic signed [SUM_BITS-1:0] csum;
    } term_bus_t;

endpackage

FILE: rtl/cpg_term.sv
// One sine/cosine series term: multiply by x^2, divide by a constant, accumulate.
module cpg_term (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                subtract,
    input  logic [cpg_pkg::MUL_BITS-1:0]        sin_mul,
    input  logic [cpg_pkg::MUL_BITS-1:0]        cos_mul,
    input  logic [cpg_pkg::SHIFT_BITS-1:0]      sin_shift,
    input  logic [cpg_pkg::SHIFT_BITS-1:0]      cos_shift,
    input  cpg_pkg::term_bus_t                  bus_in,
    output cpg_pkg::term_bus_t                  bus_out
);

    cpg_pkg::term_bus_t a_bus_reg;
    cpg_pkg::term_bus_t b_bus_reg;
    cpg_pkg::term_bus_t c_bus_next;
    cpg_pkg::term_bus_t c_bus_reg;
    logic [63:0] a_ps_reg;
    logic [63:0] a_pc_reg;
    logic [64:0] b_qs_reg;
    logic [64:0] b_qc_reg;
    logic [cpg_pkg::TERM_BITS-1:0] ts_new;
    logic [cpg_pkg::TERM_BITS-1:0] tc_new;

    // Stage A: products with x^2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_bus_reg <= '0;
            b_bus_reg <= '0;
            c_bus_reg <= '0;
        end
        else if (en)
        begin
            a_bus_reg <= bus_in;
            b_bus_reg <= a_bus_reg;
            c_bus_reg <= c_bus_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ps_reg <= 64'(bus_in.ts) * 64'(bus_in.x2);
            a_pc_reg <= 64'(bus_in.tc) * 64'(bus_in.x2);
            // Stage B: divide by constant through reciprocal multiply
            b_qs_reg <= 65'(a_ps_reg[61:30]) * 65'(sin_mul);
            b_qc_reg <= 65'(a_pc_reg[61:30]) * 65'(cos_mul);
        end
    end

    // Stage C: finish quotient and accumulate
    always_comb
    begin
        ts_new = cpg_pkg::TERM_BITS'(b_qs_reg >> sin_shift);
        tc_new = cpg_pkg::TERM_BITS'(b_qc_reg >> cos_shift);
        c_bus_next    = b_bus_reg;
        c_bus_next.ts = ts_new;
        c_bus_next.tc = tc_new;
        if (subtract)
        begin
            c_bus_next.ssum = b_bus_reg.ssum - $signed({2'b00, ts_new});
            c_bus_next.csum = b_bus_reg.csum - $signed({2'b00, tc_new});
        end
        else
        begin
            c_bus_next.ssum = b_bus_reg.ssum + $signed({2'b00, ts_new});
            c_bus_next.csum = b_bus_reg.csum + $signed({2'b00, tc_new});
        end
    end

    assign bus_out = c_bus_reg;

endmodule

FILE: rtl/circle_point_generator_core.sv
// Top level of the circle point generator: config, pipeline and pixel emitter.
//
// Usage:
//   Configuration: write center_x, center_y, circle_radius, pixel_color and
//   octant_mode through cfg_write / cfg_index / cfg_data while idle.
//   A radius write starts a bit-serial reciprocal divider; in_ready
//   stays low until it finishes.
//   Input channel (in_valid / in_ready / step_index): one transaction per angle
//   step. A new step can enter in every cycle while the pipeline advances.
//   Output channel (out_valid / out_ready / pixel_*): 8 pixels per step in
//   octant mode, 4 in quadrant mode, none past the angle limit.
//   The emitter sends all pixels of one step before it loads the next, so the
//   single output channel bounds the step rate; a step past the limit is
//   still loaded into the emitter but sends no pixel.
//   Pipeline: angle multiply, x^2, series seed, nine three-stage series terms,
//   clamp and round, radius multiply, then the emitter.
//   Reset clears all valid bits, sets radius 1, octant mode and reciprocal 1.0.
//   When the receiver stalls, the emitter holds its pixel and the whole
//   pipeline freezes once a finished step waits for the emitter.
module circle_point_generator_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [cpg_pkg::CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [cpg_pkg::COLOR_BITS-1:0]          cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [cpg_pkg::STEP_BITS-1:0]           step_index,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [cpg_pkg::PIX_BITS-1:0]     pixel_x,
    output logic signed [cpg_pkg::PIX_BITS-1:0]     pixel_y,
    output logic [cpg_pkg::COLOR_BITS-1:0]          pixel_value,
    output logic                                    last_of_step
);

    localparam int CB = cpg_pkg::COORD_BITS;
    localparam int FB = cpg_pkg::FRAC_BITS;
    localparam int PB = cpg_pkg::PIX_BITS;
    localparam int ANG_BITS = cpg_pkg::STEP_BITS + FB + 1;
    localparam int ANGQ_BITS = FB + 1 + cpg_pkg::WORK_BITS - FB;
    localparam int RND = cpg_pkg::WORK_BITS - FB;

    // ---------------- configuration registers ----------------
    logic [CB-1:0] center_x_reg;
    logic [CB-1:0] center_y_reg;
    logic [CB-1:0] radius_reg;
    logic [cpg_pkg::COLOR_BITS-1:0] color_reg;
    logic octant_reg;
    logic [CB-1:0] radius_in;

    // ---------------- reciprocal divider ----------------
    logic div_busy_reg;
    logic [4:0] div_cnt_reg;
    logic [CB-1:0] div_rem_reg;
    logic [FB:0] div_quo_reg;
    logic [CB:0] rem_shift;
    logic rem_ge;
    logic div_start;

    assign radius_in = (cfg_data[CB-1:0] == '0) ? CB'(1) : cfg_data[CB-1:0];
    assign div_start = cfg_write && (cpg_pkg::cfg_reg_t'(cfg_index) == cpg_pkg::REG_RADIUS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= CB'(1);
            color_reg    <= '0;
            octant_reg   <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cpg_pkg::cfg_reg_t'(cfg_index))
                cpg_pkg::REG_CENTER_X: center_x_reg <= cfg_data[CB-1:0];
                cpg_pkg::REG_CENTER_Y: center_y_reg <= cfg_data[CB-1:0];
                cpg_pkg::REG_RADIUS:   radius_reg   <= radius_in;
                cpg_pkg::REG_COLOR:    color_reg    <= cfg_data;
                cpg_pkg::REG_OCTANT:   octant_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Long division of 2^FRAC_BITS by the radius, one quotient bit per cycle
    assign rem_shift = {div_rem_reg, (div_cnt_reg == 5'(FB))};
    assign rem_ge    = (rem_shift >= {1'b0, radius_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
            div_rem_reg  <= '0;
            div_quo_reg  <= (FB+1)'(1) << FB;
        end
        else if (div_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= 5'(FB);
            div_rem_reg  <= '0;
            div_quo_reg  <= '0;
        end
        else if (div_busy_reg)
        begin
            div_rem_reg  <= rem_ge ? CB'(rem_shift - {1'b0, radius_reg}) : rem_shift[CB-1:0];
            div_quo_reg  <= {div_quo_reg[FB-1:0], rem_ge};
            div_cnt_reg  <= div_cnt_reg - 5'd1;
            if (div_cnt_reg == 5'd0)
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    // ---------------- pipeline ----------------
    logic en;
    logic s1_valid_reg, s2_valid_reg, s2_skip_reg;
    logic f1_valid_reg, f1_skip_reg, f2_valid_reg, f2_skip_reg;
    logic [ANG_BITS-1:0] s1_ang_reg;
    logic [ANGQ_BITS-1:0] s2_angq_reg;
    logic [2*ANGQ_BITS-1:0] s2_sq_reg;
    logic [FB:0] limit;
    logic [ANGQ_BITS-1:0] angq;
    cpg_pkg::term_bus_t bus [0:cpg_pkg::NUM_TERMS];
    cpg_pkg::term_bus_t seed_next;
    cpg_pkg::term_bus_t seed_reg;
    logic [cpg_pkg::WORK_BITS:0] cos_clamp, sin_clamp;
    logic [FB:0] cq_next, sq_next, f1_cq_reg, f1_sq_reg;
    logic [CB+FB:0] xprod, yprod;
    logic [CB-1:0] f2_x_reg, f2_y_reg;
    logic emit_load;

    assign in_ready = en && !div_busy_reg;
    assign limit = octant_reg ? cpg_pkg::LIMIT_OCT : cpg_pkg::LIMIT_QUAD;
    assign angq  = {s1_ang_reg[FB:0], RND'(0)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid && !div_busy_reg;
            s2_valid_reg <= s1_valid_reg;
            f1_valid_reg <= bus[cpg_pkg::NUM_TERMS].valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ang_reg  <= ANG_BITS'(step_index) * ANG_BITS'(div_quo_reg);
            s2_skip_reg <= (s1_ang_reg > ANG_BITS'(limit));
            s2_angq_reg <= angq;
            s2_sq_reg   <= (2*ANGQ_BITS)'(angq) * (2*ANGQ_BITS)'(angq);
            f1_skip_reg <= bus[cpg_pkg::NUM_TERMS].skip;
            f1_cq_reg   <= cq_next;
            f1_sq_reg   <= sq_next;
            f2_skip_reg <= f1_skip_reg;
            f2_x_reg    <= xprod[CB+FB-1:FB];
            f2_y_reg    <= yprod[CB+FB-1:FB];
        end
    end

    // Series seed: first terms x and 1.0
    always_comb
    begin
        seed_next.valid = s2_valid_reg;
        seed_next.skip  = s2_skip_reg;
        seed_next.x2    = s2_sq_reg[2*cpg_pkg::WORK_BITS+1:cpg_pkg::WORK_BITS];
        seed_next.ts    = cpg_pkg::TERM_BITS'(s2_angq_reg);
        seed_next.tc    = cpg_pkg::TERM_BITS'(1) << cpg_pkg::WORK_BITS;
        seed_next.ssum  = $signed(cpg_pkg::SUM_BITS'(s2_angq_reg));
        seed_next.csum  = $signed(cpg_pkg::SUM_BITS'(1) << cpg_pkg::WORK_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (en)
        begin
            seed_reg <= seed_next;
        end
    end

    assign bus[0] = seed_reg;

    genvar g;
    generate
        for (g = 0; g < cpg_pkg::NUM_TERMS; g++)
        begin : g_term
            localparam int SD = cpg_pkg::SIN_DIV[g];
            localparam int CD = cpg_pkg::COS_DIV[g];
            localparam int SL = $clog2(SD);
            localparam int CL = $clog2(CD);
            localparam logic [63:0] SM = ((64'd1 << (32 + SL)) + 64'(SD) - 64'd1) / 64'(SD);
            localparam logic [63:0] CM = ((64'd1 << (32 + CL)) + 64'(CD) - 64'd1) / 64'(CD);

            cpg_term u_term (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .subtract  ((g % 2) == 0),
                .sin_mul   (SM[cpg_pkg::MUL_BITS-1:0]),
                .cos_mul   (CM[cpg_pkg::MUL_BITS-1:0]),
                .sin_shift (cpg_pkg::SHIFT_BITS'(32 + SL)),
                .cos_shift (cpg_pkg::SHIFT_BITS'(32 + CL)),
                .bus_in    (bus[g]),
                .bus_out   (bus[g+1])
            );
        end
    endgenerate

    // Clamp to [0, 1.0] and round half up to FRAC_BITS
    always_comb
    begin
        if (bus[cpg_pkg::NUM_TERMS].csum < 0)
            cos_clamp = '0;
        else if (bus[cpg_pkg::NUM_TERMS].csum > $signed(cpg_pkg::SUM_BITS'(1) << cpg_pkg::WORK_BITS))
            cos_clamp = (cpg_pkg::WORK_BITS+1)'(1) << cpg_pkg::WORK_BITS;
        else
            cos_clamp = bus[cpg_pkg::NUM_TERMS].csum[cpg_pkg::WORK_BITS:0];
        if (bus[cpg_pkg::NUM_TERMS].ssum < 0)
            sin_clamp = '0;
        else if (bus[cpg_pkg::NUM_TERMS].ssum > $signed(cpg_pkg::SUM_BITS'(1) << cpg_pkg::WORK_BITS))
            sin_clamp = (cpg_pkg::WORK_BITS+1)'(1) << cpg_pkg::WORK_BITS;
        else
            sin_clamp = bus[cpg_pkg::NUM_TERMS].ssum[cpg_pkg::WORK_BITS:0];
        cq_next = (FB+1)'((cos_clamp + (cpg_pkg::WORK_BITS+1)'(1 << (RND-1))) >> RND);
        sq_next = (FB+1)'((sin_clamp + (cpg_pkg::WORK_BITS+1)'(1 << (RND-1))) >> RND);
    end

    assign xprod = (CB+FB+1)'(radius_reg) * (CB+FB+1)'(f1_cq_reg);
    assign yprod = (CB+FB+1)'(radius_reg) * (CB+FB+1)'(f1_sq_reg);

    // ---------------- pixel emitter ----------------
    logic em_busy_reg;
    logic [2:0] em_cnt_reg;
    logic [CB-1:0] em_x_reg, em_y_reg;
    logic out_fire, em_last;
    logic [PB-1:0] cx, cy, dx, dy;

    assign out_fire  = out_valid && out_ready;
    assign em_last   = octant_reg ? (em_cnt_reg == 3'd7) : (em_cnt_reg == 3'd3);
    assign emit_load = f2_valid_reg && (!em_busy_reg || (out_fire && em_last));
    // Advance unless a finished step waits for the emitter
    assign en        = !f2_valid_reg || emit_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_busy_reg <= 1'b0;
            em_cnt_reg  <= '0;
        end
        else if (emit_load)
        begin
            em_busy_reg <= !f2_skip_reg;
            em_cnt_reg  <= '0;
        end
        else if (out_fire)
        begin
            em_cnt_reg <= em_cnt_reg + 3'd1;
            if (em_last)
            begin
                em_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            em_x_reg <= f2_x_reg;
            em_y_reg <= f2_y_reg;
        end
    end

    assign cx = PB'(center_x_reg);
    assign cy = PB'(center_y_reg);
    assign dx = PB'(em_x_reg);
    assign dy = PB'(em_y_reg);

    always_comb
    begin
        pixel_x = '0;
        pixel_y = '0;
        if (octant_reg)
        begin
            case (em_cnt_reg)
                3'd0: begin pixel_x = cx + dx; pixel_y = cy + dy; end
                3'd1: begin pixel_x = cx + dy; pixel_y = cy + dx; end
                3'd2: begin pixel_x = cx - dy; pixel_y = cy + dx; end
                3'd3: begin pixel_x = cx - dx; pixel_y = cy + dy; end
                3'd4: begin pixel_x = cx - dx; pixel_y = cy - dy; end
                3'd5: begin pixel_x = cx - dy; pixel_y = cy - dx; end
                3'd6: begin pixel_x = cx + dy; pixel_y = cy - dx; end
                default: begin pixel_x = cx + dx; pixel_y = cy - dy; end
            endcase
        end
        else
        begin
            case (em_cnt_reg)
                3'd0: begin pixel_x = cx - dx; pixel_y = cy - dy; end
                3'd1: begin pixel_x = cx + dx; pixel_y = cy - dy; end
                3'd2: begin pixel_x = cx - dx; pixel_y = cy + dy; end
                default: begin pixel_x = cx + dx; pixel_y = cy + dy; end
            endcase
        end
    end

    assign out_valid    = em_busy_reg;
    assign pixel_value  = color_reg;
    assign last_of_step = em_last;

endmodule

FILE: rtl/cpg_checker.sv
// Port-level checker of the circle point generator and its bind.
`include "circle_point_generator_core_macros.svh"

module cpg_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [cpg_pkg::CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [cpg_pkg::COLOR_BITS-1:0]          cfg_data,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic [cpg_pkg::STEP_BITS-1:0]           step_index,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic signed [cpg_pkg::PIX_BITS-1:0]     pixel_x,
    input  logic signed [cpg_pkg::PIX_BITS-1:0]     pixel_y,
    input  logic [cpg_pkg::COLOR_BITS-1:0]          pixel_value,
    input  logic                                    last_of_step
);

    `CPG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out_valid dropped")
    `CPG_ASSERT_NEXT(a_out_stable, out_valid && !out_ready && !cfg_write,
        $stable(pixel_x) && $stable(pixel_y) && $stable(last_of_step), "stalled pixel changed")
    `CPG_ASSERT_SEQ(a_step_continues, out_valid && out_ready && !last_of_step && !cfg_write,
        ##1 out_valid, "step ended before its last pixel")
    `CPG_ASSERT_NEXT(a_div_blocks, cfg_write && (cfg_index == cpg_pkg::REG_RADIUS),
        !in_ready, "input taken while reciprocal updates")

endmodule

bind circle_point_generator_core cpg_checker u_cpg_checker (.*);

FILE: tb/circle_point_generator_core_tb.sv
// Testbench for the circle point generator core: config phases, random steps, pixel checks.
`timescale 1ns / 100ps

module circle_point_generator_core_tb;

    localparam int PHASE_STEPS   = 26;
    localparam int DRAIN_CYCLES  = 60;     // pipeline latency plus emitter, with margin
    localparam int STALL_LIMIT   = 3000;   // idle cycles before the watchdog fires
    localparam logic [cpg_pkg::CFG_IDX_BITS-1:0] UNUSED_REG = 3'd7;

    typedef struct {
        logic signed [cpg_pkg::PIX_BITS-1:0] x;
        logic signed [cpg_pkg::PIX_BITS-1:0] y;
        logic [cpg_pkg::COLOR_BITS-1:0]      color;
        logic                                last;
    } pixel_t;

    // Predicts the mirrored pixels of each accepted step and checks them in order.
    class pixel_scoreboard;
        bit [cpg_pkg::COORD_BITS-1:0] center_x;
        bit [cpg_pkg::COORD_BITS-1:0] center_y;
        bit [cpg_pkg::COORD_BITS-1:0] radius;
        bit [cpg_pkg::COLOR_BITS-1:0] color;
        bit                           octant;
        pixel_t                       pixel_q[$];
        int                           errors;

        function new();
            center_x = 0;
            center_y = 0;
            radius   = 1;
            color    = 0;
            octant   = 1;
            errors   = 0;
        endfunction

        function void write_reg(logic [cpg_pkg::CFG_IDX_BITS-1:0] idx,
                                logic [cpg_pkg::COLOR_BITS-1:0] data);
            case (idx)
                cpg_pkg::REG_CENTER_X: center_x = data[cpg_pkg::COORD_BITS-1:0];
                cpg_pkg::REG_CENTER_Y: center_y = data[cpg_pkg::COORD_BITS-1:0];
                cpg_pkg::REG_RADIUS:   radius   = data[cpg_pkg::COORD_BITS-1:0];
                cpg_pkg::REG_COLOR:    color    = data;
                cpg_pkg::REG_OCTANT:   octant   = data[0];
                default: ;
            endcase
        endfunction

        function bit [63:0] eff_radius();
            return (radius == 0) ? 64'd1 : 64'(radius);
        endfunction

        function bit [63:0] angle_limit();
            bit [63:0] pi4;
            pi4 = 64'hC90FDAA22168C235;
            if (octant)
                return (pi4 + (64'd1 << 43)) >> 44;
            return (pi4 + (64'd1 << 42)) >> 43;
        endfunction

        function bit [63:0] recip();
            return (64'd1 << cpg_pkg::FRAC_BITS) / eff_radius();
        endfunction

        // Largest step that still lands inside the angle limit.
        function int max_step();
            return int'(angle_limit() / recip());
        endfunction

        function bit [63:0] clamp_unit(longint v);
            if (v < 0)
                return 0;
            if (v > (longint'(1) << cpg_pkg::WORK_BITS))
                return 64'd1 << cpg_pkg::WORK_BITS;
            return 64'(v);
        endfunction

        // Truncating Taylor series in Q30, the first term plus nine more each.
        function void sincos_q30(bit [63:0] ang, output bit [63:0] cv, output bit [63:0] sv);
            bit [63:0] x2;
            bit [63:0] ts;
            bit [63:0] tc;
            longint    ssum;
            longint    csum;
            x2 = (ang * ang) >> cpg_pkg::WORK_BITS;
            ts = ang;
            tc = 64'd1 << cpg_pkg::WORK_BITS;
            ssum = longint'(ts);
            csum = longint'(tc);
            for (int n = 1; n <= cpg_pkg::NUM_TERMS; n++)
            begin
                ts = ((ts * x2) >> cpg_pkg::WORK_BITS) / 64'((2 * n) * (2 * n + 1));
                tc = ((tc * x2) >> cpg_pkg::WORK_BITS) / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1)
                begin
                    ssum -= longint'(ts);
                    csum -= longint'(tc);
                end
                else
                begin
                    ssum += longint'(ts);
                    csum += longint'(tc);
                end
            end
            cv = clamp_unit(csum);
            sv = clamp_unit(ssum);
        endfunction

        function void push_pixel(longint px, longint py, bit last);
            pixel_t p;
            p.x     = px[cpg_pkg::PIX_BITS-1:0];
            p.y     = py[cpg_pkg::PIX_BITS-1:0];
            p.color = color;
            p.last  = last;
            pixel_q.push_back(p);
        endfunction

        function void note_step(bit [cpg_pkg::STEP_BITS-1:0] k);
            bit [63:0] ang;
            bit [63:0] cq;
            bit [63:0] sq;
            longint    x;
            longint    y;
            longint    cx;
            longint    cy;
            ang = 64'(k) * recip();
            if (ang > angle_limit())
                return;
            sincos_q30(ang << (cpg_pkg::WORK_BITS - cpg_pkg::FRAC_BITS), cq, sq);
            cq = (cq + (64'd1 << (cpg_pkg::WORK_BITS - cpg_pkg::FRAC_BITS - 1)))
                 >> (cpg_pkg::WORK_BITS - cpg_pkg::FRAC_BITS);
            sq = (sq + (64'd1 << (cpg_pkg::WORK_BITS - cpg_pkg::FRAC_BITS - 1)))
                 >> (cpg_pkg::WORK_BITS - cpg_pkg::FRAC_BITS);
            x  = longint'((eff_radius() * cq) >> cpg_pkg::FRAC_BITS);
            y  = longint'((eff_radius() * sq) >> cpg_pkg::FRAC_BITS);
            cx = longint'(center_x);
            cy = longint'(center_y);
            if (octant)
            begin
                push_pixel(cx + x, cy + y, 0);
                push_pixel(cx + y, cy + x, 0);
                push_pixel(cx - y, cy + x, 0);
                push_pixel(cx - x, cy + y, 0);
                push_pixel(cx - x, cy - y, 0);
                push_pixel(cx - y, cy - x, 0);
                push_pixel(cx + y, cy - x, 0);
                push_pixel(cx + x, cy - y, 1);
            end
            else
            begin
                push_pixel(cx - x, cy - y, 0);
                push_pixel(cx + x, cy - y, 0);
                push_pixel(cx - x, cy + y, 0);
                push_pixel(cx + x, cy + y, 1);
            end
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_pixel(pixel_t got);
            pixel_t want;
            if (pixel_q.size() == 0)
            begin
                report_mismatch("unexpected pixel x", got.x, 0);
                return;
            end
            want = pixel_q.pop_front();
            if (got.x !== want.x)
                report_mismatch("pixel_x", got.x, want.x);
            if (got.y !== want.y)
                report_mismatch("pixel_y", got.y, want.y);
            if (got.color !== want.color)
                report_mismatch("pixel_value", got.color, want.color);
            if (got.last !== want.last)
                report_mismatch("last_of_step", got.last, want.last);
        endtask
    endclass

    logic                                   clk;
    logic                                   rst_n;
    logic                                   cfg_write;
    logic [cpg_pkg::CFG_IDX_BITS-1:0]       cfg_index;
    logic [cpg_pkg::COLOR_BITS-1:0]         cfg_data;
    logic                                   in_valid;
    logic                                   in_ready;
    logic [cpg_pkg::STEP_BITS-1:0]          step_index;
    logic                                   out_valid;
    logic                                   out_ready;
    logic signed [cpg_pkg::PIX_BITS-1:0]    pixel_x;
    logic signed [cpg_pkg::PIX_BITS-1:0]    pixel_y;
    logic [cpg_pkg::COLOR_BITS-1:0]         pixel_value;
    logic                                   last_of_step;

    pixel_scoreboard pixels = new();
    bit              quiet;          // no random gaps on either side while set
    int              stall_left;
    int              idle_cycles;

    circle_point_generator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .step_index   (step_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_value  (pixel_value),
        .last_of_step (last_of_step)
    );

    initial
    begin
        clk = 0;
    end

    always #10 clk = ~clk;

    // Mostly short gaps, now and then a long one; none in quiet stretches.
    function automatic int pick_gap();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return 0;
        if (roll < 9)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver: check every accepted pixel transaction, then pick the next ready.
    always @(posedge clk)
    begin
        pixel_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.x     = pixel_x;
                got.y     = pixel_y;
                got.color = pixel_value;
                got.last  = last_of_step;
                pixels.check_pixel(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap();
                out_ready <= (stall_left == 0);
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a transaction.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("circle_point_generator_core_tb: errors");
            $finish;
        end
    end

    task wait_for_pixels();
        while (pixels.pixel_q.size() != 0)
            @(posedge clk);
    endtask

    // Drain everything, then hold off long enough for steps past the limit.
    task settle();
        wait_for_pixels();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the registers back to back, then drop the write enable.
    task write_config(logic [cpg_pkg::COLOR_BITS-1:0] cx, logic [cpg_pkg::COLOR_BITS-1:0] cy,
                      logic [cpg_pkg::COLOR_BITS-1:0] rad, logic [cpg_pkg::COLOR_BITS-1:0] color,
                      logic [cpg_pkg::COLOR_BITS-1:0] oct);
        logic [cpg_pkg::CFG_IDX_BITS-1:0] idx [6];
        logic [cpg_pkg::COLOR_BITS-1:0]   val [6];
        idx = '{cpg_pkg::REG_CENTER_X, cpg_pkg::REG_CENTER_Y, cpg_pkg::REG_RADIUS,
                cpg_pkg::REG_COLOR, cpg_pkg::REG_OCTANT, UNUSED_REG};
        val = '{cx, cy, rad, color, oct, $urandom()};
        for (int i = 0; i < 6; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            pixels.write_reg(idx[i], val[i]);
        end
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Hold valid and the step until the transaction goes through.
    task send_step(logic [cpg_pkg::STEP_BITS-1:0] k);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        step_index <= k;
        do
            @(posedge clk);
        while (!in_ready);
        pixels.note_step(k);
    endtask

    task run_phase(int count);
        int top;
        top = pixels.max_step();
        if (top > 8190)
            top = 8190;
        // Edges first: zero angle, the last step in range, the first past it, the top code
        send_step(0);
        send_step(cpg_pkg::STEP_BITS'(top));
        send_step(cpg_pkg::STEP_BITS'(top + 1));
        send_step({cpg_pkg::STEP_BITS{1'b1}});
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
            begin
                in_valid <= 1'b0;
                wait_for_pixels();
            end
            if ($urandom_range(0, 3) != 0)
                send_step(cpg_pkg::STEP_BITS'($urandom_range(0, top + 1)));
            else
                send_step(cpg_pkg::STEP_BITS'($urandom_range(0, 8191)));
        end
        in_valid <= 1'b0;
        settle();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = cpg_pkg::REG_CENTER_X;
        cfg_data    = '0;
        in_valid    = 1'b0;
        step_index  = '0;
        out_ready   = 1'b0;
        quiet       = 1'b0;
        stall_left  = 0;
        idle_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (30) @(posedge clk);

        // Reset values: center at origin, radius 1, octant mode
        run_phase(PHASE_STEPS);
        write_config(4095, 4095, 4095, 32'hFFFF_FFFF, 1);
        run_phase(PHASE_STEPS);
        quiet = 1'b1;
        write_config(0, 0, 0, 32'h0000_0000, 0);
        run_phase(PHASE_STEPS);
        quiet = 1'b0;
        write_config(4095, 0, 4095, 32'hA5A5_5A5A, 0);
        run_phase(PHASE_STEPS);
        // Upper data bits set on the coordinate registers must be dropped
        write_config(32'hFFFF_F800, 32'h1234_5064, 37, $urandom(), 2);
        run_phase(PHASE_STEPS);
        write_config($urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(1, 300), $urandom(), 1);
        run_phase(PHASE_STEPS);
        write_config($urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(1, 4095), $urandom(), 0);
        run_phase(PHASE_STEPS);

        if (pixels.errors == 0)
            $display("circle_point_generator_core_tb: clean");
        else
            $display("circle_point_generator_core_tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/cpg_pkg.sv
rtl/cpg_term.sv
rtl/circle_point_generator_core.sv
rtl/cpg_checker.sv
tb/circle_point_generator_core_tb.sv
